[hdl/cssi_pkg.sv]
`timescale 1ns / 1ps
// cssi_pkg: shared types and widths for the circle / segment intersection block.
// No dependencies; cssi_front, cssi_back and the top level import it.
package cssi_pkg;

  localparam int unsigned QDEPTH_DEF = 4;   // default depth of the front/back queue
  localparam int unsigned A_W        = 65;  // |d|^2, unsigned
  localparam int unsigned MUL_HALF   = 33;  // half width of the split wide multiplier
  localparam int unsigned ROOT_W     = 64;  // floor(sqrt(D)), D < 2^127
  localparam int unsigned DIVD_W     = 98;  // N * |d| < 2^97
  localparam int unsigned QUO_W      = 33;  // |floor(N * d / A)| <= |d| < 2^32

  // one queued transaction, already split into sign / magnitude form
  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        dxs;
    logic        dys;
    logic        exs;
    logic        eys;
    logic [31:0] dxm;
    logic [31:0] dym;
    logic [31:0] exm;
    logic [31:0] eym;
    logic [30:0] r;
    logic        degen;
  } cssi_item_t;

  // segment data carried down the back pipeline to the point stage
  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        dxs;
    logic        dys;
    logic [31:0] dxm;
    logic [31:0] dym;
  } cssi_seg_t;

endpackage

[hdl/cssi_mul.sv]
`timescale 1ns / 1ps
// cssi_mul: pipelined unsigned multiplier, operands split in halves.
// Carries a sideband word alongside. Depends on nothing.
module cssi_mul #(
  parameter int unsigned HW = 33,
  parameter int unsigned SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [2*HW-1:0]   a_i,
  input  logic [2*HW-1:0]   b_i,
  input  logic [SW-1:0]     side_i,
  output logic              vld_o,
  output logic [4*HW-1:0]   p_o,
  output logic [SW-1:0]     side_o
);

  logic [2:0]          vld_q;
  logic [2*HW-1:0]     p00_q, p01_q, p10_q, p11_q;
  logic [4*HW-1:0]     lo_q;
  logic [2*HW:0]       mid_q;
  logic [4*HW-1:0]     p_q;
  logic [SW-1:0]       side1_q, side2_q, side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // partial products
  always_ff @(posedge clk_i) begin
    p00_q   <= a_i[HW-1:0]    * b_i[HW-1:0];
    p01_q   <= a_i[HW-1:0]    * b_i[2*HW-1:HW];
    p10_q   <= a_i[2*HW-1:HW] * b_i[HW-1:0];
    p11_q   <= a_i[2*HW-1:HW] * b_i[2*HW-1:HW];
    side1_q <= side_i;
  end

  // outer terms just concatenate, cross terms add
  always_ff @(posedge clk_i) begin
    lo_q    <= {p11_q, p00_q};
    mid_q   <= (2*HW+1)'(p01_q) + (2*HW+1)'(p10_q);
    side2_q <= side1_q;
  end

  always_ff @(posedge clk_i) begin
    p_q     <= lo_q + (4*HW)'({mid_q, {HW{1'b0}}});
    side3_q <= side2_q;
  end

  assign vld_o  = vld_q[2];
  assign p_o    = p_q;
  assign side_o = side3_q;

endmodule

[hdl/cssi_sqrt.sv]
`timescale 1ns / 1ps
// cssi_sqrt: pipelined floor square root, one result bit per stage.
// Carries a sideband word alongside. Depends on nothing.
module cssi_sqrt #(
  parameter int unsigned RW = 64,
  parameter int unsigned SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [SW-1:0]     side_i,
  output logic              vld_o,
  output logic [RW-1:0]     root_o,
  output logic [SW-1:0]     side_o
);

  logic              vld_q  [RW];
  logic [2*RW-1:0]   rad_q  [RW];
  logic [RW+1:0]     rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [SW-1:0]     side_q [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic            vld_in;
    logic [2*RW-1:0] rad_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [SW-1:0]   side_in;
    logic [RW+3:0]   tmp;
    logic [RW+3:0]   trial;
    logic            ge;

    if (g == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign side_in = side_q[g-1];
    end

    assign tmp   = {rem_in, rad_in[2*RW-1 -: 2]};
    assign trial = (RW+4)'({root_in, 2'b01});
    assign ge    = (tmp >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[g]  <= rad_in << 2;
      rem_q[g]  <= (RW+2)'(ge ? tmp - trial : tmp);
      root_q[g] <= {root_in[RW-2:0], ge};
      side_q[g] <= side_in;
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign side_o = side_q[RW-1];

endmodule

[hdl/cssi_div.sv]
`timescale 1ns / 1ps
// cssi_div: pipelined restoring divider, one quotient bit per stage.
// Needs dividend < divisor * 2^QW. Depends on nothing.
module cssi_div #(
  parameter int unsigned NW = 98,
  parameter int unsigned DW = 65,
  parameter int unsigned QW = 33,
  parameter int unsigned SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [NW-1:0]   n_i,
  input  logic [DW-1:0]   d_i,
  input  logic [SW-1:0]   side_i,
  output logic            vld_o,
  output logic [QW-1:0]   q_o,
  output logic            rnz_o,
  output logic [SW-1:0]   side_o
);

  logic            vld_q  [QW];
  logic [NW-1:0]   rem_q  [QW];
  logic [DW-1:0]   d_q    [QW];
  logic [QW-1:0]   q_q    [QW];
  logic [SW-1:0]   side_q [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int unsigned Sh = QW - 1 - g;
    logic            vld_in;
    logic [NW-1:0]   rem_in;
    logic [DW-1:0]   d_in;
    logic [QW-1:0]   q_in;
    logic [SW-1:0]   side_in;
    logic [NW-1:0]   trial;
    logic            ge;

    if (g == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = n_i;
      assign d_in    = d_i;
      assign q_in    = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign d_in    = d_q[g-1];
      assign q_in    = q_q[g-1];
      assign side_in = side_q[g-1];
    end

    assign trial = NW'(d_in) << Sh;
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= ge ? rem_in - trial : rem_in;
      d_q[g]    <= d_in;
      q_q[g]    <= q_in | (QW'(ge) << Sh);
      side_q[g] <= side_in;
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign q_o    = q_q[QW-1];
  assign rnz_o  = (rem_q[QW-1] != '0);
  assign side_o = side_q[QW-1];

endmodule

[hdl/cssi_front.sv]
`timescale 1ns / 1ps
// cssi_front: takes transactions, forms segment and offset vectors, queues them.
// Depends on cssi_pkg.
module cssi_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic signed [31:0]    center_x_i,
  input  logic signed [31:0]    center_y_i,
  input  logic [30:0]           circle_radius_i,
  input  logic signed [31:0]    start_x_i,
  input  logic signed [31:0]    start_y_i,
  input  logic signed [31:0]    end_x_i,
  input  logic signed [31:0]    end_y_i,
  output logic                  item_vld_o,
  output cssi_pkg::cssi_item_t  item_o
);
  import cssi_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cssi_item_t        mem [DEPTH];
  cssi_item_t        item_d, item_q;
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              vld_q;
  logic              push, pop;
  logic signed [32:0] dx, dy, ex, ey;

  // classify: differences in 33 bits, then sign and magnitude
  always_comb begin
    dx = 33'(end_x_i) - 33'(start_x_i);
    dy = 33'(end_y_i) - 33'(start_y_i);
    ex = 33'(start_x_i) - 33'(center_x_i);
    ey = 33'(start_y_i) - 33'(center_y_i);
    item_d.sx    = start_x_i;
    item_d.sy    = start_y_i;
    item_d.dxs   = dx[32];
    item_d.dys   = dy[32];
    item_d.exs   = ex[32];
    item_d.eys   = ey[32];
    item_d.dxm   = 32'(dx[32] ? -dx : dx);
    item_d.dym   = 32'(dy[32] ? -dy : dy);
    item_d.exm   = 32'(ex[32] ? -ex : ex);
    item_d.eym   = 32'(ey[32] ? -ey : ey);
    item_d.r     = circle_radius_i;
    item_d.degen = (dx == '0) && (dy == '0);
  end

  assign busy_o = (cnt_q == CW'(DEPTH));
  assign push   = start_i && !busy_o;
  assign pop    = (cnt_q != '0);   // the back end never stalls

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      vld_q    <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      vld_q    <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= item_d;
    end
    if (pop) begin
      item_q <= mem[rd_ptr_q];
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_vld_from_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> item_vld_o)
    else $error("queued entry not handed to back end");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("accepted transaction not counted");

endmodule

[hdl/cssi_back.sv]
`timescale 1ns / 1ps
// cssi_back: quadratic setup, discriminant, square root, root selection, points.
// Depends on cssi_pkg, cssi_mul, cssi_sqrt, cssi_div.
module cssi_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_vld_i,
  input  cssi_pkg::cssi_item_t  item_i,
  output logic                  done_o,
  output logic                  line_hits_o,
  output logic                  on_segment_o,
  output logic                  degenerate_o,
  output logic signed [31:0]    first_x_o,
  output logic signed [31:0]    first_y_o,
  output logic signed [31:0]    second_x_o,
  output logic signed [31:0]    second_y_o
);
  import cssi_pkg::*;

  localparam int unsigned PW = 4 * MUL_HALF;

  typedef struct packed {
    cssi_seg_t          seg;
    logic               degen;
    logic [A_W-1:0]     a;
    logic signed [65:0] h;
    logic               cs;
  } m1_side_t;

  typedef struct packed {
    cssi_seg_t          seg;
    logic               degen;
    logic [A_W-1:0]     a;
    logic signed [65:0] h;
    logic               dneg;
  } sq_side_t;

  typedef struct packed {
    cssi_seg_t          seg;
    logic [A_W-1:0]     a;
    logic               lh;
    logic               os;
    logic               degen;
  } m2_side_t;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        dxs;
    logic        dys;
    logic        lh;
    logic        os;
    logic        degen;
  } dv_side_t;

  // start + floor(q signed), clamped to 32 bits
  function automatic logic signed [31:0] cssi_coord(input logic [31:0] s, input logic neg,
                                                    input logic [QUO_W-1:0] q,
                                                    input logic rnz);
    logic signed [34:0] qv;
    logic signed [34:0] v;
    qv = neg ? -$signed(35'(q) + 35'(rnz)) : $signed(35'(q));
    v  = 35'($signed(s)) + qv;
    if (v > 35'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -35'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // ---- stage 1: dot-product terms -------------------------------------
  logic        s1_vld_q;
  cssi_seg_t   s1_seg_q, seg_in;
  logic        s1_degen_q, s1_hs0_q, s1_hs1_q;
  logic [63:0] s1_dxx_q, s1_dyy_q, s1_dxe_q, s1_dye_q, s1_exx_q, s1_eyy_q;
  logic [61:0] s1_rr_q;

  always_comb begin
    seg_in.sx  = item_i.sx;
    seg_in.sy  = item_i.sy;
    seg_in.dxs = item_i.dxs;
    seg_in.dys = item_i.dys;
    seg_in.dxm = item_i.dxm;
    seg_in.dym = item_i.dym;
  end

  always_ff @(posedge clk_i) begin
    s1_seg_q   <= seg_in;
    s1_degen_q <= item_i.degen;
    s1_hs0_q   <= item_i.dxs ^ item_i.exs;
    s1_hs1_q   <= item_i.dys ^ item_i.eys;
    s1_dxx_q   <= item_i.dxm * item_i.dxm;
    s1_dyy_q   <= item_i.dym * item_i.dym;
    s1_dxe_q   <= item_i.dxm * item_i.exm;
    s1_dye_q   <= item_i.dym * item_i.eym;
    s1_exx_q   <= item_i.exm * item_i.exm;
    s1_eyy_q   <= item_i.eym * item_i.eym;
    s1_rr_q    <= item_i.r * item_i.r;
  end

  // ---- stage 2: A, H, |e|^2 -------------------------------------------
  logic               s2_vld_q;
  cssi_seg_t          s2_seg_q;
  logic               s2_degen_q;
  logic [A_W-1:0]     s2_a_q, s2_e_q;
  logic signed [65:0] s2_h_q, h_t0, h_t1;
  logic [61:0]        s2_rr_q;

  always_comb begin
    h_t0 = s1_hs0_q ? -$signed({2'b00, s1_dxe_q}) : $signed({2'b00, s1_dxe_q});
    h_t1 = s1_hs1_q ? -$signed({2'b00, s1_dye_q}) : $signed({2'b00, s1_dye_q});
  end

  always_ff @(posedge clk_i) begin
    s2_seg_q   <= s1_seg_q;
    s2_degen_q <= s1_degen_q;
    s2_a_q     <= A_W'(s1_dxx_q) + A_W'(s1_dyy_q);
    s2_e_q     <= A_W'(s1_exx_q) + A_W'(s1_eyy_q);
    s2_h_q     <= h_t0 + h_t1;
    s2_rr_q    <= s1_rr_q;
  end

  // ---- stage 3: C and magnitudes --------------------------------------
  logic               s3_vld_q;
  m1_side_t           s3_side_q;
  logic [A_W-1:0]     s3_hm_q, s3_cm_q;
  logic signed [65:0] c_c;

  assign c_c = $signed({1'b0, s2_e_q}) - $signed({4'b0000, s2_rr_q});

  always_ff @(posedge clk_i) begin
    s3_side_q.seg   <= s2_seg_q;
    s3_side_q.degen <= s2_degen_q;
    s3_side_q.a     <= s2_a_q;
    s3_side_q.h     <= s2_h_q;
    s3_side_q.cs    <= c_c[65];
    s3_hm_q         <= A_W'(s2_h_q[65] ? -s2_h_q : s2_h_q);
    s3_cm_q         <= A_W'(c_c[65] ? -c_c : c_c);
  end

  // ---- H^2 and A*|C| --------------------------------------------------
  logic              m1_vld;
  m1_side_t          m1_side;
  logic [PW-1:0]     m1_hh, m1_ac;

  cssi_mul #(.HW(MUL_HALF), .SW($bits(m1_side_t))) u_mul_hh (
    .clk_i, .rst_ni,
    .vld_i  (s3_vld_q),
    .a_i    ((2*MUL_HALF)'(s3_hm_q)),
    .b_i    ((2*MUL_HALF)'(s3_hm_q)),
    .side_i (s3_side_q),
    .vld_o  (m1_vld),
    .p_o    (m1_hh),
    .side_o (m1_side)
  );

  cssi_mul #(.HW(MUL_HALF), .SW(1)) u_mul_ac (
    .clk_i, .rst_ni,
    .vld_i  (s3_vld_q),
    .a_i    ((2*MUL_HALF)'(s3_side_q.a)),
    .b_i    ((2*MUL_HALF)'(s3_cm_q)),
    .side_i (1'b0),
    .vld_o  (),
    .p_o    (m1_ac),
    .side_o ()
  );

  // ---- stage 4: discriminant / 4 --------------------------------------
  logic                s4_vld_q;
  sq_side_t            s4_side_q;
  logic [2*ROOT_W-1:0] s4_dm_q;
  logic signed [PW:0]  d_c;

  assign d_c = m1_side.cs ? $signed({1'b0, m1_hh}) + $signed({1'b0, m1_ac})
                          : $signed({1'b0, m1_hh}) - $signed({1'b0, m1_ac});

  always_ff @(posedge clk_i) begin
    s4_side_q.seg   <= m1_side.seg;
    s4_side_q.degen <= m1_side.degen;
    s4_side_q.a     <= m1_side.a;
    s4_side_q.h     <= m1_side.h;
    s4_side_q.dneg  <= d_c[PW];
    s4_dm_q         <= d_c[2*ROOT_W-1:0];
  end

  // ---- floor square root ----------------------------------------------
  logic              sq_vld;
  sq_side_t          sq_side;
  logic [ROOT_W-1:0] sq_root;

  cssi_sqrt #(.RW(ROOT_W), .SW($bits(sq_side_t))) u_sqrt (
    .clk_i, .rst_ni,
    .vld_i  (s4_vld_q),
    .rad_i  (s4_dm_q),
    .side_i (s4_side_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // ---- stage 5: root numerators ---------------------------------------
  logic               s5_vld_q;
  sq_side_t           s5_side_q;
  logic signed [66:0] s5_n1_q, s5_n2_q, h_x, s_x;

  assign h_x = 67'(sq_side.h);
  assign s_x = $signed({3'b000, sq_root});

  always_ff @(posedge clk_i) begin
    s5_side_q <= sq_side;
    s5_n1_q   <= -h_x - s_x;
    s5_n2_q   <= s_x - h_x;
  end

  // ---- stage 6: range check and pick ----------------------------------
  logic           s6_vld_q;
  m2_side_t       s6_side_q;
  logic [A_W-1:0] s6_n1_q, s6_n2_q;
  logic           ok1, ok2;

  always_comb begin
    ok1 = !s5_n1_q[66] && (s5_n1_q <= $signed({2'b00, s5_side_q.a}));
    ok2 = !s5_n2_q[66] && (s5_n2_q <= $signed({2'b00, s5_side_q.a}));
  end

  always_ff @(posedge clk_i) begin
    s6_side_q.seg   <= s5_side_q.seg;
    s6_side_q.a     <= s5_side_q.a;
    s6_side_q.lh    <= !s5_side_q.dneg;
    s6_side_q.os    <= (ok1 || ok2) && !s5_side_q.dneg && !s5_side_q.degen;
    s6_side_q.degen <= s5_side_q.degen;
    s6_n1_q         <= A_W'(ok1 ? s5_n1_q : s5_n2_q);
    s6_n2_q         <= A_W'(ok2 ? s5_n2_q : s5_n1_q);
  end

  // ---- N * |d| ---------------------------------------------------------
  logic          m2_vld;
  m2_side_t      m2_side;
  logic [PW-1:0] p_x1, p_y1, p_x2, p_y2;

  cssi_mul #(.HW(MUL_HALF), .SW($bits(m2_side_t))) u_mul_x1 (
    .clk_i, .rst_ni,
    .vld_i  (s6_vld_q),
    .a_i    ((2*MUL_HALF)'(s6_n1_q)),
    .b_i    ((2*MUL_HALF)'(s6_side_q.seg.dxm)),
    .side_i (s6_side_q),
    .vld_o  (m2_vld),
    .p_o    (p_x1),
    .side_o (m2_side)
  );

  cssi_mul #(.HW(MUL_HALF), .SW(1)) u_mul_y1 (
    .clk_i, .rst_ni,
    .vld_i  (s6_vld_q),
    .a_i    ((2*MUL_HALF)'(s6_n1_q)),
    .b_i    ((2*MUL_HALF)'(s6_side_q.seg.dym)),
    .side_i (1'b0),
    .vld_o  (),
    .p_o    (p_y1),
    .side_o ()
  );

  cssi_mul #(.HW(MUL_HALF), .SW(1)) u_mul_x2 (
    .clk_i, .rst_ni,
    .vld_i  (s6_vld_q),
    .a_i    ((2*MUL_HALF)'(s6_n2_q)),
    .b_i    ((2*MUL_HALF)'(s6_side_q.seg.dxm)),
    .side_i (1'b0),
    .vld_o  (),
    .p_o    (p_x2),
    .side_o ()
  );

  cssi_mul #(.HW(MUL_HALF), .SW(1)) u_mul_y2 (
    .clk_i, .rst_ni,
    .vld_i  (s6_vld_q),
    .a_i    ((2*MUL_HALF)'(s6_n2_q)),
    .b_i    ((2*MUL_HALF)'(s6_side_q.seg.dym)),
    .side_i (1'b0),
    .vld_o  (),
    .p_o    (p_y2),
    .side_o ()
  );

  // ---- divide by A ------------------------------------------------------
  dv_side_t          dv_in, dv_side;
  logic              dv_vld;
  logic [QUO_W-1:0]  q_x1, q_y1, q_x2, q_y2;
  logic              r_x1, r_y1, r_x2, r_y2;

  always_comb begin
    dv_in.sx    = m2_side.seg.sx;
    dv_in.sy    = m2_side.seg.sy;
    dv_in.dxs   = m2_side.seg.dxs;
    dv_in.dys   = m2_side.seg.dys;
    dv_in.lh    = m2_side.lh;
    dv_in.os    = m2_side.os;
    dv_in.degen = m2_side.degen;
  end

  cssi_div #(.NW(DIVD_W), .DW(A_W), .QW(QUO_W), .SW($bits(dv_side_t))) u_div_x1 (
    .clk_i, .rst_ni,
    .vld_i  (m2_vld),
    .n_i    (p_x1[DIVD_W-1:0]),
    .d_i    (m2_side.a),
    .side_i (dv_in),
    .vld_o  (dv_vld),
    .q_o    (q_x1),
    .rnz_o  (r_x1),
    .side_o (dv_side)
  );

  cssi_div #(.NW(DIVD_W), .DW(A_W), .QW(QUO_W), .SW(1)) u_div_y1 (
    .clk_i, .rst_ni,
    .vld_i  (m2_vld),
    .n_i    (p_y1[DIVD_W-1:0]),
    .d_i    (m2_side.a),
    .side_i (1'b0),
    .vld_o  (),
    .q_o    (q_y1),
    .rnz_o  (r_y1),
    .side_o ()
  );

  cssi_div #(.NW(DIVD_W), .DW(A_W), .QW(QUO_W), .SW(1)) u_div_x2 (
    .clk_i, .rst_ni,
    .vld_i  (m2_vld),
    .n_i    (p_x2[DIVD_W-1:0]),
    .d_i    (m2_side.a),
    .side_i (1'b0),
    .vld_o  (),
    .q_o    (q_x2),
    .rnz_o  (r_x2),
    .side_o ()
  );

  cssi_div #(.NW(DIVD_W), .DW(A_W), .QW(QUO_W), .SW(1)) u_div_y2 (
    .clk_i, .rst_ni,
    .vld_i  (m2_vld),
    .n_i    (p_y2[DIVD_W-1:0]),
    .d_i    (m2_side.a),
    .side_i (1'b0),
    .vld_o  (),
    .q_o    (q_y2),
    .rnz_o  (r_y2),
    .side_o ()
  );

  // ---- stage 7: points, result register -----------------------------
  logic               done_q, lh_q, os_q, dg_q;
  logic signed [31:0] fx_q, fy_q, sx_q, sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= item_vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= m1_vld;
      s5_vld_q <= sq_vld;
      s6_vld_q <= s5_vld_q;
      done_q   <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    lh_q <= dv_side.lh;
    os_q <= dv_side.os;
    dg_q <= dv_side.degen;
    fx_q <= dv_side.os ? cssi_coord(dv_side.sx, dv_side.dxs, q_x1, r_x1) : '0;
    fy_q <= dv_side.os ? cssi_coord(dv_side.sy, dv_side.dys, q_y1, r_y1) : '0;
    sx_q <= dv_side.os ? cssi_coord(dv_side.sx, dv_side.dxs, q_x2, r_x2) : '0;
    sy_q <= dv_side.os ? cssi_coord(dv_side.sy, dv_side.dys, q_y2, r_y2) : '0;
  end

  assign done_o       = done_q;
  assign line_hits_o  = lh_q;
  assign on_segment_o = os_q;
  assign degenerate_o = dg_q;
  assign first_x_o    = fx_q;
  assign first_y_o    = fy_q;
  assign second_x_o   = sx_q;
  assign second_y_o   = sy_q;

  a_degen_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (line_hits_o && !on_segment_o))
    else $error("zero-length segment reported with a hit point");

  a_miss_no_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !line_hits_o) |-> !on_segment_o)
    else $error("segment hit without line hit");

  a_no_pts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !on_segment_o) |-> (first_x_o == '0 && first_y_o == '0 &&
                                   second_x_o == '0 && second_y_o == '0))
    else $error("points not cleared on miss");

endmodule

[hdl/circle_segment_intersection.sv]
`timescale 1ns / 1ps
// circle_segment_intersection: top level, circle / line-segment intersection in fixed point.
// Depends on cssi_pkg, cssi_front, cssi_back (and the units under cssi_back).
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+-----------------------------
//   query in | center_x/y_i, circle_radius_i,               | taken when start && !busy
//            | start_x/y_i, end_x/y_i                       |
//   result   | line_hits_o, on_segment_o, degenerate_o,     | done_o high for one cycle,
//            | first_x/y_o, second_x/y_o                    | no back-pressure
//
// One transaction per clock cycle, sustained while busy is low. Between the accepting
// edge and done_o the registers are, in order: queue, setup, H^2/A*C, discriminant,
// square root, numerators and pick, N*d, divider, result register.
// A short queue decouples the classifying front end from the arithmetic pipeline; the
// pipeline always advances, so busy only rises if the queue fills.
// Reset (rst_ni low, asynchronous) empties the queue and all valid flags; no data is
// cleared. The receiver cannot stall: each result is presented exactly once.
module circle_segment_intersection #(
  parameter int unsigned QUEUE_DEPTH = cssi_pkg::QDEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic [30:0]        circle_radius_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  output logic               done_o,
  output logic               line_hits_o,
  output logic               on_segment_o,
  output logic               degenerate_o,
  output logic signed [31:0] first_x_o,
  output logic signed [31:0] first_y_o,
  output logic signed [31:0] second_x_o,
  output logic signed [31:0] second_y_o
);
  import cssi_pkg::*;

  // queued transaction between the two halves
  logic       item_vld;
  cssi_item_t item;

  // front: forms d = end - start and e = start - center as sign/magnitude,
  // flags a zero-length segment, and writes the queue
  cssi_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i,
    .rst_ni,
    .start_i         (start),
    .busy_o          (busy),
    .center_x_i,
    .center_y_i,
    .circle_radius_i,
    .start_x_i,
    .start_y_i,
    .end_x_i,
    .end_y_i,
    .item_vld_o      (item_vld),
    .item_o          (item)
  );

  // back: A = d.d, H = d.e, C = e.e - r^2, D = H^2 - A*C, S = floor(sqrt(D)),
  // N = -H -/+ S, keep roots with 0 <= N <= A, point = start + floor(N*d/A)
  cssi_back u_back (
    .clk_i,
    .rst_ni,
    .item_vld_i   (item_vld),
    .item_i       (item),
    .done_o,
    .line_hits_o,
    .on_segment_o,
    .degenerate_o,
    .first_x_o,
    .first_y_o,
    .second_x_o,
    .second_y_o
  );

endmodule
